FILE: rtl/rhd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_pkg: shared types and codes for the range hazard detector
// Label record as held in a table cell, per-cell hit record, cell control
// group, kind/hazard/result codes and the hazard classification function.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;

  localparam logic [1:0] HAZ_RAW   = 2'd0;
  localparam logic [1:0] HAZ_WAW   = 2'd1;
  localparam logic [1:0] HAZ_OTHER = 2'd2;

  localparam logic RES_HAZARD = 1'b0;
  localparam logic RES_FULL   = 1'b1;

  // lo is the range start, hi is start + length (wraps at 64 bits)
  typedef struct packed {
    logic [63:0] id;
    logic [2:0]  kind;
    logic [31:0] key;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        has_range;
  } label_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] dep;
    logic [63:0] pre;
    logic [1:0]  haz;
  } hit_t;

  typedef struct packed {
    logic kill;
    logic clear;
  } cell_ctrl_t;

  function automatic logic [1:0] classify(input logic [2:0] early_kind,
                                          input logic [2:0] late_kind);
    logic [1:0] haz;
    haz = HAZ_OTHER;
    if (early_kind == KIND_WRITE && late_kind == KIND_READ) begin
      haz = HAZ_RAW;
    end else if (early_kind == KIND_WRITE && late_kind == KIND_WRITE) begin
      haz = HAZ_WAW;
    end
    return haz;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/range_hazard_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// range_hazard_detector: I/O label range hazard detection
// Each label is checked against the stored labels of its group; one beat is
// produced per overlapping pair that is not two reads, plus one beat when the
// table is full.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the label fields and raise start; the label is taken at an edge
//   where start is high and busy is low. busy drops in the cycle that
//   carries the last beat for that label.
//   Results appear as single-cycle beats marked by result_strobe; there is no
//   back-pressure, so the receiver must take each beat in the cycle it shows.
//   last_of_run marks the final beat of a label; a label with no hazard and
//   room in the table produces no beat at all.
//   The probe walks the cell chain one cell per cycle, so a label with N
//   stored entries in the table keeps busy high while the probe passes those
//   N cells, ends the walk and drains; the next label waits until busy is low.
//   Each beat is held until the next overlap is found or the walk ends, so it
//   is sent only after the cell that found the overlap has passed the probe on.
//   cfg_write/cfg_data set the grouping mode (1 = by application, 0 = by
//   file); write it only while busy is low. The key is taken at accept.
//   Reset empties the table and selects grouping by file. A label with
//   batch_end set empties the table after its beats are sent.
// ----------------------------------------------------------------------------
module range_hazard_detector #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] seq_id,
  input  wire logic [2:0]  label_kind,
  input  wire logic [31:0] app_number,
  input  wire logic [31:0] file_number,
  input  wire logic [63:0] range_start,
  input  wire logic [63:0] range_length,
  input  wire logic        batch_end,
  output logic             result_strobe,
  output logic             result_kind,
  output logic [63:0]      dependent_id,
  output logic [63:0]      prerequisite_id,
  output logic [1:0]       hazard,
  output logic             last_of_run
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       pos;
  logic [CW-1:0]       count;
  logic                head_valid;
  logic                group_by_app;
  logic                batch_last;
  rhd_pkg::label_t     probe;

  logic                pend_valid;
  logic                pend_kind;
  logic [63:0]         pend_dep;
  logic [63:0]         pend_pre;
  logic [1:0]          pend_haz;

  logic                accept;
  logic                finish;
  logic                full;
  rhd_pkg::hit_t       hit_sum;
  rhd_pkg::cell_ctrl_t cell_ctrl;

  rhd_pkg::label_t     chain_probe [0:TABLE_DEPTH];
  logic [TABLE_DEPTH:0] chain_valid;
  rhd_pkg::hit_t       cell_hit    [0:TABLE_DEPTH-1];
  logic [TABLE_DEPTH-1:0] wr_sel;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign finish = (state == S_WALK) && (pos == count);
  assign full   = (count == CW'(TABLE_DEPTH));

  assign cell_ctrl.kill  = finish;
  assign cell_ctrl.clear = (state == S_DRAIN) && batch_last;

  assign chain_probe[0] = probe;
  assign chain_valid[0] = head_valid;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign wr_sel[g] = finish && !full && (count == CW'(g));
      rhd_cell u_cell (
        .clk            (clk),
        .rst            (rst),
        .ctrl           (cell_ctrl),
        .wr_en          (wr_sel[g]),
        .wr_data        (probe),
        .probe_in       (chain_probe[g]),
        .probe_in_valid (chain_valid[g]),
        .probe_out      (chain_probe[g+1]),
        .probe_out_valid(chain_valid[g+1]),
        .result         (cell_hit[g])
      );
    end
  endgenerate

  // at most one cell sees the probe, so the OR picks out its hit
  always_comb begin
    hit_sum = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_sum = hit_sum | cell_hit[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      count         <= '0;
      head_valid    <= 1'b0;
      group_by_app  <= 1'b0;
      pend_valid    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      head_valid    <= accept;
      result_strobe <= 1'b0;
      if (cfg_write) begin
        group_by_app <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WALK;
            pos   <= '0;
          end
        end
        S_WALK: begin
          if (finish) begin
            state <= S_DRAIN;
            if (full) begin
              result_strobe <= pend_valid;
              pend_valid    <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
          end else begin
            pos <= pos + CW'(1);
            if (hit_sum.hit) begin
              result_strobe <= pend_valid;
              pend_valid    <= 1'b1;
            end
          end
        end
        S_DRAIN: begin
          result_strobe <= pend_valid;
          pend_valid    <= 1'b0;
          state         <= S_IDLE;
          if (batch_last) begin
            count <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload: hold the pending beat until the next one (or the end) is known
  always_ff @(posedge clk) begin
    if (accept) begin
      probe.id        <= seq_id;
      probe.kind      <= label_kind;
      probe.key       <= group_by_app ? app_number : file_number;
      probe.lo        <= range_start;
      probe.hi        <= range_start + range_length;
      probe.has_range <= (range_length != 64'd0);
      batch_last      <= batch_end;
    end
    result_kind     <= pend_kind;
    dependent_id    <= pend_dep;
    prerequisite_id <= pend_pre;
    hazard          <= pend_haz;
    last_of_run     <= (state == S_DRAIN);
    if (finish && full) begin
      pend_kind <= rhd_pkg::RES_FULL;
      pend_dep  <= probe.id;
      pend_pre  <= 64'd0;
      pend_haz  <= rhd_pkg::HAZ_RAW;
    end else if ((state == S_WALK) && !finish && hit_sum.hit) begin
      pend_kind <= rhd_pkg::RES_HAZARD;
      pend_dep  <= hit_sum.dep;
      pend_pre  <= hit_sum.pre;
      pend_haz  <= hit_sum.haz;
    end
  end

  a_one_probe: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one probe in the cell chain");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state) != S_IDLE)
    else $error("result beat without a label in flight");

  a_full_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result_kind == rhd_pkg::RES_FULL) |-> last_of_run)
    else $error("overflow beat is not the last of its run");

  a_batch_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && batch_last) |=> count == '0)
    else $error("table not emptied after batch end");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> pos <= count)
    else $error("probe walked past the filled entries");

endmodule
`default_nettype wire

FILE: rtl/rhd_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_cell: one table entry of the hazard detector chain
// Holds one stored label, checks the probe passing through it this cycle and
// hands the probe on to the next cell at the clock edge.
// ----------------------------------------------------------------------------
module rhd_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rhd_pkg::cell_ctrl_t ctrl,
  input  wire logic                wr_en,
  input  wire rhd_pkg::label_t     wr_data,
  input  wire rhd_pkg::label_t     probe_in,
  input  wire logic                probe_in_valid,
  output rhd_pkg::label_t          probe_out,
  output logic                     probe_out_valid,
  output rhd_pkg::hit_t            result
);

  logic            valid;
  rhd_pkg::label_t entry;
  logic            meet;
  logic            both_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= 1'b0;
      probe_out_valid <= 1'b0;
    end else begin
      probe_out_valid <= probe_in_valid && !ctrl.kill;
      if (ctrl.clear) begin
        valid <= 1'b0;
      end else if (wr_en) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_out <= probe_in;
    if (wr_en) begin
      entry <= wr_data;
    end
  end

  always_comb begin
    meet = valid && probe_in_valid && (entry.key == probe_in.key) &&
           entry.has_range && probe_in.has_range &&
           (entry.lo < probe_in.hi) && (probe_in.lo < entry.hi);
    both_read = (entry.kind == rhd_pkg::KIND_READ) &&
                (probe_in.kind == rhd_pkg::KIND_READ);
    result = '0;
    if (meet && !both_read) begin
      result.hit = 1'b1;
      // on equal ids the stored label is the earlier one
      if (probe_in.id < entry.id) begin
        result.dep = entry.id;
        result.pre = probe_in.id;
        result.haz = rhd_pkg::classify(probe_in.kind, entry.kind);
      end else begin
        result.dep = probe_in.id;
        result.pre = entry.id;
        result.haz = rhd_pkg::classify(entry.kind, probe_in.kind);
      end
    end
  end

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: range hazard detector testbench
// Sends I/O labels through the start/busy handshake and checks every result
// beat, field by field, against a local copy of the label table. Covers
// directed corner cases, a full table, grouping changes inside a batch and
// random batches under several sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_DEPTH = 32;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int WATCHDOG_CYCLES = 300000;

  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_FLUSH  = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;
  localparam logic [2:0] KIND_RSVD5  = 3'd5;
  localparam logic [2:0] KIND_RSVD6  = 3'd6;
  localparam logic [2:0] KIND_RSVD7  = 3'd7;
  localparam logic [63:0] ALL_ONES64 = '1;

  typedef struct packed {
    logic [63:0] id;
    logic [2:0]  kind;
    logic [31:0] app;
    logic [31:0] file;
    logic [63:0] ofs;
    logic [63:0] len;
    logic        batch_end;
  } label_rec_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] dep;
    logic [63:0] pre;
    logic [1:0]  haz;
    logic        tail;
  } beat_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        start;
  logic        busy;
  logic [63:0] seq_id;
  logic [2:0]  label_kind;
  logic [31:0] app_number;
  logic [31:0] file_number;
  logic [63:0] range_start;
  logic [63:0] range_length;
  logic        batch_end;
  logic        result_strobe;
  logic        result_kind;
  logic [63:0] dependent_id;
  logic [63:0] prerequisite_id;
  logic [1:0]  hazard;
  logic        last_of_run;

  // table mirror and grouping mode
  logic        mode_by_app;
  logic        tbl_valid [TABLE_DEPTH];
  logic [63:0] tbl_id    [TABLE_DEPTH];
  logic [2:0]  tbl_kind  [TABLE_DEPTH];
  logic [31:0] tbl_key   [TABLE_DEPTH];
  logic [63:0] tbl_start [TABLE_DEPTH];
  logic [63:0] tbl_len   [TABLE_DEPTH];

  beat_rec_t beats_due[$];
  beat_rec_t want;

  int err_count;
  int labels_sent;
  int cfg_writes;
  int hazards_checked;
  int overflows_checked;
  logic [63:0] next_id;
  logic [63:0] prev_id;

  range_hazard_detector #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .seq_id(seq_id),
    .label_kind(label_kind),
    .app_number(app_number),
    .file_number(file_number),
    .range_start(range_start),
    .range_length(range_length),
    .batch_end(batch_end),
    .result_strobe(result_strobe),
    .result_kind(result_kind),
    .dependent_id(dependent_id),
    .prerequisite_id(prerequisite_id),
    .hazard(hazard),
    .last_of_run(last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 20) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // half-open ranges, sums wrap at 64 bits
  function automatic logic spans_touch(input logic [63:0] s1, l1, s2, l2);
    if (l1 == '0 || l2 == '0) return 1'b0;
    return (s1 < s2 + l2) && (s2 < s1 + l1);
  endfunction

  function automatic logic [1:0] pair_hazard(input logic [2:0] early, late);
    if (early != rhd_pkg::KIND_WRITE) return rhd_pkg::HAZ_OTHER;
    if (late == rhd_pkg::KIND_READ) return rhd_pkg::HAZ_RAW;
    if (late == rhd_pkg::KIND_WRITE) return rhd_pkg::HAZ_WAW;
    return rhd_pkg::HAZ_OTHER;
  endfunction

  function automatic beat_rec_t make_beat(input logic kind, input logic [63:0] dep, pre,
                                          input logic [1:0] haz);
    beat_rec_t b;
    b.kind = kind;
    b.dep = dep;
    b.pre = pre;
    b.haz = haz;
    b.tail = 1'b0;
    return b;
  endfunction

  function automatic label_rec_t lbl(input logic [63:0] id, input logic [2:0] kind,
                                     input logic [31:0] app, file,
                                     input logic [63:0] ofs, len, input logic last_one);
    label_rec_t l;
    l.id = id;
    l.kind = kind;
    l.app = app;
    l.file = file;
    l.ofs = ofs;
    l.len = len;
    l.batch_end = last_one;
    return l;
  endfunction

  // Work out the beats one accepted label causes and update the table mirror.
  task automatic predict_label(input label_rec_t l);
    beat_rec_t run [TABLE_DEPTH+1];
    logic [31:0] key;
    int n;
    int free_slot;
    key = mode_by_app ? l.app : l.file;
    n = 0;
    free_slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tbl_valid[i]) begin
        if (free_slot < 0) free_slot = i;
      end else if (tbl_key[i] == key &&
                   spans_touch(tbl_start[i], tbl_len[i], l.ofs, l.len) &&
                   !(tbl_kind[i] == rhd_pkg::KIND_READ &&
                     l.kind == rhd_pkg::KIND_READ)) begin
        // stored label wins a tie on id
        if (l.id < tbl_id[i])
          run[n] = make_beat(rhd_pkg::RES_HAZARD, tbl_id[i], l.id,
                             pair_hazard(l.kind, tbl_kind[i]));
        else
          run[n] = make_beat(rhd_pkg::RES_HAZARD, l.id, tbl_id[i],
                             pair_hazard(tbl_kind[i], l.kind));
        n++;
      end
    end
    if (free_slot < 0) begin
      run[n] = make_beat(rhd_pkg::RES_FULL, l.id, '0, rhd_pkg::HAZ_RAW);
      n++;
    end else begin
      tbl_valid[free_slot] = 1'b1;
      tbl_id[free_slot] = l.id;
      tbl_kind[free_slot] = l.kind;
      tbl_key[free_slot] = key;
      tbl_start[free_slot] = l.ofs;
      tbl_len[free_slot] = l.len;
    end
    if (n > 0) run[n-1].tail = 1'b1;
    for (int k = 0; k < n; k++) beats_due.insert(beats_due.size(), run[k]);
    if (l.batch_end) begin
      for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    end
  endtask

  // Leaves start high on return; the caller lowers it when it idles.
  task automatic send_label(input label_rec_t l);
    start <= 1'b1;
    seq_id <= l.id;
    label_kind <= l.kind;
    app_number <= l.app;
    file_number <= l.file;
    range_start <= l.ofs;
    range_length <= l.len;
    batch_end <= l.batch_end;
    do @(posedge clk); while (busy !== 1'b0);
    predict_label(l);
    labels_sent++;
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // Hold off until every beat is in, then let a label without beats finish.
  task automatic drain_results();
    start <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_mode(input logic by_app);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data <= by_app;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_by_app = by_app;
    cfg_writes++;
  endtask

  function automatic label_rec_t random_label(input int batch_div);
    label_rec_t l;
    int pick;
    pick = $urandom_range(99);
    next_id += $urandom_range(1, 3);
    if (pick < 75) l.id = next_id;
    else if (pick < 85) l.id = rand64();
    else if (pick < 92) l.id = prev_id;
    else l.id = next_id - $urandom_range(1, 20);
    prev_id = l.id;

    pick = $urandom_range(99);
    if (pick < 35) l.kind = rhd_pkg::KIND_READ;
    else if (pick < 65) l.kind = rhd_pkg::KIND_WRITE;
    else l.kind = 3'($urandom_range(KIND_DELETE, KIND_RSVD7));

    l.app = ($urandom_range(99) < 85) ? 32'($urandom_range(0, 2)) : 32'($urandom);
    l.file = ($urandom_range(99) < 85) ? 32'($urandom_range(0, 2)) : 32'($urandom);

    pick = $urandom_range(99);
    if (pick < 80) l.ofs = 64'($urandom_range(0, 255));
    else if (pick < 90) l.ofs = ALL_ONES64 - $urandom_range(0, 255);
    else l.ofs = rand64();

    pick = $urandom_range(99);
    if (pick < 15) l.len = '0;
    else if (pick < 75) l.len = 64'($urandom_range(1, 64));
    else if (pick < 88) l.len = rand64();
    else l.len = ALL_ONES64 - $urandom_range(0, 255);

    l.batch_end = ($urandom_range(batch_div - 1) == 0);
    return l;
  endfunction

  // Boundaries, every kind, id order and ties, wrapping ranges, batch clear.
  task automatic test_directed();
    send_label(lbl(64'd10, rhd_pkg::KIND_WRITE, 32'd5, 32'd1, 64'd100, 64'd50, 1'b0));
    send_label(lbl(64'd11, rhd_pkg::KIND_READ, 32'd5, 32'd1, 64'd120, 64'd10, 1'b0));
    send_label(lbl(64'd12, rhd_pkg::KIND_WRITE, 32'd5, 32'd1, 64'd140, 64'd20, 1'b0));
    // ends exactly where the first write begins
    send_label(lbl(64'd13, rhd_pkg::KIND_READ, 32'd5, 32'd1, 64'd0, 64'd100, 1'b0));
    send_label(lbl(64'd14, rhd_pkg::KIND_READ, 32'd5, 32'd1, 64'd149, 64'd1, 1'b0));
    // smaller id arriving late becomes the earlier label
    send_label(lbl(64'd9, rhd_pkg::KIND_READ, 32'd5, 32'd1, 64'd125, 64'd1, 1'b0));
    send_label(lbl(64'd12, rhd_pkg::KIND_WRITE, 32'd5, 32'd1, 64'd150, 64'd5, 1'b0));
    send_label(lbl(64'd15, rhd_pkg::KIND_READ, 32'd5, 32'd1, 64'd100, 64'd0, 1'b0));
    send_label(lbl(64'd20, KIND_DELETE, 32'd5, 32'd1, 64'd100, 64'd1, 1'b0));
    send_label(lbl(64'd21, KIND_FLUSH, 32'd5, 32'd2, 64'd100, 64'd100, 1'b0));
    send_label(lbl(64'd22, KIND_OTHER, 32'd5, 32'd1, 64'd0, ALL_ONES64, 1'b0));
    send_label(lbl(64'd23, KIND_RSVD5, 32'd5, 32'd1, 64'd110, 64'd4, 1'b0));
    send_label(lbl(64'd24, KIND_RSVD6, 32'd5, 32'd1, 64'd200, 64'd8, 1'b0));
    send_label(lbl(64'd25, KIND_RSVD7, 32'd5, 32'd2, 64'd100, 64'd1, 1'b0));
    // range end wraps past zero
    send_label(lbl(64'd26, rhd_pkg::KIND_WRITE, 32'd5, 32'd3, ALL_ONES64 - 64'd15, 64'd32,
                   1'b0));
    send_label(lbl(64'd27, rhd_pkg::KIND_READ, 32'd5, 32'd3, 64'd0, 64'd8, 1'b0));
    send_label(lbl(64'd28, rhd_pkg::KIND_READ, 32'd5, 32'd3, ALL_ONES64 - 64'd7, 64'd4,
                   1'b0));
    send_label(lbl(ALL_ONES64, rhd_pkg::KIND_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0,
                   64'd1, 1'b0));
    send_label(lbl(64'd0, rhd_pkg::KIND_READ, 32'd0, 32'hFFFF_FFFF, 64'd0, 64'd1, 1'b0));
    send_label(lbl(64'd30, rhd_pkg::KIND_READ, 32'hFFFF_FFFF, 32'd1, ALL_ONES64, ALL_ONES64,
                   1'b1));
    // table must be empty again
    send_label(lbl(64'd31, rhd_pkg::KIND_WRITE, 32'd5, 32'd1, 64'd100, 64'd50, 1'b0));
    send_label(lbl(64'd32, rhd_pkg::KIND_READ, 32'd5, 32'd1, 64'd100, 64'd50, 1'b1));
  endtask

  // Keys stored under file grouping are compared against application keys.
  task automatic test_group_switch();
    send_label(lbl(64'd100, rhd_pkg::KIND_WRITE, 32'd7, 32'd50, 64'd0, 64'd10, 1'b0));
    write_group_mode(1'b1);
    send_label(lbl(64'd101, rhd_pkg::KIND_READ, 32'd50, 32'd7, 64'd0, 64'd5, 1'b0));
    send_label(lbl(64'd102, rhd_pkg::KIND_READ, 32'd7, 32'd50, 64'd0, 64'd5, 1'b0));
    send_label(lbl(64'd103, rhd_pkg::KIND_WRITE, 32'd50, 32'd0, 64'd2, 64'd1, 1'b1));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_label(lbl(64'd2000 + i, rhd_pkg::KIND_WRITE, 32'd300 + i, 32'd0, 64'd0, 64'd16,
                     1'b0));
    send_label(lbl(64'd2100, rhd_pkg::KIND_READ, 32'd310, 32'd0, 64'd8, 64'd4, 1'b0));
    send_label(lbl(64'd2101, KIND_OTHER, 32'd999, 32'd0, 64'd0, 64'd0, 1'b1));
    send_label(lbl(64'd2102, rhd_pkg::KIND_WRITE, 32'd300, 32'd0, 64'd0, 64'd16, 1'b1));
  endtask

  task automatic test_random(input int count, input int idle_pct, input int batch_div);
    for (int k = 0; k < count; k++) begin
      send_label(random_label(batch_div));
      if ($urandom_range(24) == 0) drain_results();
      else sender_gap(idle_pct);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe === 1'b1) begin
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("beat with nothing expected: dep=%h pre=%h",
                                  dependent_id, prerequisite_id));
      end else begin
        want = beats_due.pop_front();
        if (want.kind == rhd_pkg::RES_FULL) overflows_checked++;
        else hazards_checked++;
        if (result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %b, want %b", result_kind, want.kind));
        if (dependent_id !== want.dep)
          report_mismatch($sformatf("dependent_id %h, want %h", dependent_id, want.dep));
        if (prerequisite_id !== want.pre)
          report_mismatch($sformatf("prerequisite_id %h, want %h", prerequisite_id, want.pre));
        if (hazard !== want.haz)
          report_mismatch($sformatf("hazard %0d, want %0d (dep=%h)", hazard, want.haz,
                                    want.dep));
        if (last_of_run !== want.tail)
          report_mismatch($sformatf("last_of_run %b, want %b (dep=%h)", last_of_run,
                                    want.tail, want.dep));
      end
    end
  end

  initial begin
    #(4 * WATCHDOG_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    start <= 1'b0;
    seq_id <= '0;
    label_kind <= rhd_pkg::KIND_READ;
    app_number <= '0;
    file_number <= '0;
    range_start <= '0;
    range_length <= '0;
    batch_end <= 1'b0;
    mode_by_app = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    err_count = 0;
    labels_sent = 0;
    cfg_writes = 0;
    hazards_checked = 0;
    overflows_checked = 0;
    next_id = 64'd5000;
    prev_id = 64'd5000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_group_switch();
    test_table_full();
    write_group_mode(1'b0);
    test_random(75, 0, 10);
    write_group_mode(1'b1);
    test_random(75, 45, 12);
    write_group_mode(1'b0);
    // long batches fill the table
    test_random(75, 21, 50);
    write_group_mode(1'b1);
    test_random(65, 0, 40);

    start <= 1'b0;
    for (int w = 0; w < 5000 && beats_due.size() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (beats_due.size() != 0)
      report_mismatch($sformatf("%0d beats never arrived", beats_due.size()));

    $display("Summary: %0d labels sent across %0d grouping changes", labels_sent, cfg_writes);
    $display("Summary: %0d hazard beats and %0d table-full beats checked",
             hazards_checked, overflows_checked);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
